// ----- sv/amlc_pkg.sv -----
// Package for the automatic mouse layer controller.
// Holds field types, event and action codes, configuration layout and sizing constants.
// No dependencies.
package amlc_pkg;

    localparam int LAYER_COUNT    = 32;
    localparam int POSITION_COUNT = 128;
    localparam int IDLE_MS_RESET  = 1000;

    typedef logic [2:0]  t_func;
    typedef logic [1:0]  t_action;
    typedef logic [4:0]  t_layer;
    typedef logic [6:0]  t_pos;
    typedef logic [15:0] t_ms;
    typedef logic [14:0] t_prior_ms;

    localparam t_func FUNC_TICK     = 3'd0;
    localparam t_func FUNC_MOTION   = 3'd1;
    localparam t_func FUNC_POSITION = 3'd2;
    localparam t_func FUNC_KEYCODE  = 3'd3;
    localparam t_func FUNC_REPORT   = 3'd4;

    localparam t_action ACT_NONE       = 2'd0;
    localparam t_action ACT_ACTIVATE   = 2'd1;
    localparam t_action ACT_DEACTIVATE = 2'd2;

    localparam logic [2:0] REG_IDLE_MS       = 3'd0;
    localparam logic [2:0] REG_PRIOR_IDLE_MS = 3'd1;
    localparam logic [2:0] REG_CTRL_LAYER    = 3'd2;
    localparam logic [2:0] REG_EXCLUDED_LOW  = 3'd3;
    localparam logic [2:0] REG_EXCLUDED_HIGH = 3'd4;

    localparam logic [127:0] POS_MASK = (POSITION_COUNT >= 128) ? '1 :
        ((128'd1 << POSITION_COUNT) - 128'd1);

    typedef struct packed {
        t_ms          idle_ms;
        t_prior_ms    prior_idle_ms;
        t_layer       ctrl_layer;
        logic [63:0]  excluded_low;
        logic [63:0]  excluded_high;
    } t_cfg;

endpackage

// ----- sv/amlc_evt_if.sv -----
// Event channel interface for the automatic mouse layer controller.
// Carries valid, ready and one event; depends on amlc_pkg.
interface amlc_evt_if;
    logic               valid;
    logic               ready;
    amlc_pkg::t_func    func;
    logic               pressed;
    amlc_pkg::t_pos     position;
    logic               layer_still_on;

    modport source(output valid, func, pressed, position, layer_still_on, input ready);
    modport sink(input valid, func, pressed, position, layer_still_on, output ready);
endinterface

// ----- sv/amlc_res_if.sv -----
// Result channel interface for the automatic mouse layer controller.
// Carries valid, ready and one result; depends on amlc_pkg.
interface amlc_res_if;
    logic               valid;
    logic               ready;
    amlc_pkg::t_action  action;
    amlc_pkg::t_layer   layer;
    logic               active;

    modport source(output valid, action, layer, active, input ready);
    modport sink(input valid, action, layer, active, output ready);
endinterface

// ----- sv/amlc_cfg_regs.sv -----
// APB-style configuration register file for the automatic mouse layer controller.
// Registers sit at byte address 8*i; depends on amlc_pkg.
module amlc_cfg_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [5:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready,
    output amlc_pkg::t_cfg      o_cfg
);
    import amlc_pkg::*;

    t_cfg r_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.idle_ms       <= t_ms'(IDLE_MS_RESET);
            r_cfg.prior_idle_ms <= '0;
            r_cfg.ctrl_layer    <= '0;
            r_cfg.excluded_low  <= '0;
            r_cfg.excluded_high <= '0;
        end else if (w_wr) begin
            unique case (paddr[5:3])
                REG_IDLE_MS:       r_cfg.idle_ms       <= pwdata[15:0];
                REG_PRIOR_IDLE_MS: r_cfg.prior_idle_ms <= pwdata[14:0];
                REG_CTRL_LAYER:    r_cfg.ctrl_layer    <= pwdata[4:0];
                REG_EXCLUDED_LOW:  r_cfg.excluded_low  <= pwdata;
                REG_EXCLUDED_HIGH: r_cfg.excluded_high <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[5:3])
            REG_IDLE_MS:       prdata = {48'd0, r_cfg.idle_ms};
            REG_PRIOR_IDLE_MS: prdata = {49'd0, r_cfg.prior_idle_ms};
            REG_CTRL_LAYER:    prdata = {59'd0, r_cfg.ctrl_layer};
            REG_EXCLUDED_LOW:  prdata = r_cfg.excluded_low;
            REG_EXCLUDED_HIGH: prdata = r_cfg.excluded_high;
            default:           prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;
endmodule

// ----- sv/amlc_core.sv -----
// Event register, layer state update and result register of the mouse layer controller.
// Depends on amlc_pkg, amlc_evt_if and amlc_res_if.
module amlc_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  amlc_pkg::t_cfg  i_cfg,
    amlc_evt_if.sink        i_evt,
    amlc_res_if.source      o_res
);
    import amlc_pkg::*;

    logic       r_s1_valid;
    t_func      r_s1_func;
    logic       r_s1_pressed;
    t_pos       r_s1_pos;
    logic       r_s1_still_on;

    logic       r_active;
    t_ms        r_since_tap;
    t_ms        r_idle_left;

    logic       r_out_valid;
    t_action    r_out_action;
    t_layer     r_out_layer;
    logic       r_out_active;

    logic       n_active;
    t_ms        n_since_tap;
    t_ms        n_idle_left;
    t_action    n_action;

    logic       w_out_free;
    logic       w_advance;
    logic       w_in_fire;
    logic       w_layer_ok;
    logic       w_excl_any;
    logic       w_excluded;
    logic [127:0] w_bitmap;

    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_advance  = r_s1_valid && w_out_free;
    assign i_evt.ready = !r_s1_valid || w_advance;
    assign w_in_fire  = i_evt.valid && i_evt.ready;

    assign w_bitmap   = {i_cfg.excluded_high, i_cfg.excluded_low} & POS_MASK;
    assign w_excl_any = |w_bitmap;
    assign w_excluded = w_bitmap[r_s1_pos] && ({1'b0, r_s1_pos} < 8'(POSITION_COUNT));
    assign w_layer_ok = {4'd0, i_cfg.ctrl_layer} < 9'(LAYER_COUNT);

    always_comb begin
        n_active    = r_active;
        n_since_tap = r_since_tap;
        n_idle_left = r_idle_left;
        n_action    = ACT_NONE;
        case (r_s1_func)
            FUNC_TICK: begin
                if (r_since_tap != 16'hFFFF) begin
                    n_since_tap = r_since_tap + 16'd1;
                end
                if (r_idle_left != '0) begin
                    n_idle_left = r_idle_left - 16'd1;
                    if (r_idle_left == 16'd1 && r_active) begin
                        n_active = 1'b0;
                        n_action = ACT_DEACTIVATE;
                    end
                end
            end
            FUNC_MOTION: begin
                if (w_layer_ok) begin
                    if (!r_active && r_since_tap >= {1'b0, i_cfg.prior_idle_ms}) begin
                        n_active = 1'b1;
                        n_action = ACT_ACTIVATE;
                    end
                    if (i_cfg.idle_ms != '0) begin
                        n_idle_left = i_cfg.idle_ms;
                    end
                end
            end
            FUNC_POSITION: begin
                if (r_s1_pressed && r_active && w_excl_any && !w_excluded) begin
                    n_active = 1'b0;
                    n_action = ACT_DEACTIVATE;
                end
            end
            FUNC_KEYCODE: begin
                if (r_s1_pressed) begin
                    n_since_tap = '0;
                end
            end
            FUNC_REPORT: begin
                if (!r_s1_still_on) begin
                    n_active    = 1'b0;
                    n_idle_left = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_active    <= 1'b0;
            r_since_tap <= '0;
            r_idle_left <= '0;
        end else begin
            if (i_evt.ready) begin
                r_s1_valid <= i_evt.valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_s1_valid;
            end
            if (w_advance) begin
                r_active    <= n_active;
                r_since_tap <= n_since_tap;
                r_idle_left <= n_idle_left;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1_func     <= i_evt.func;
            r_s1_pressed  <= i_evt.pressed;
            r_s1_pos      <= i_evt.position;
            r_s1_still_on <= i_evt.layer_still_on;
        end
        if (w_advance) begin
            r_out_action <= n_action;
            r_out_layer  <= (n_action != ACT_NONE) ? i_cfg.ctrl_layer : '0;
            r_out_active <= n_active;
        end
    end

    assign o_res.valid  = r_out_valid;
    assign o_res.action = r_out_action;
    assign o_res.layer  = r_out_layer;
    assign o_res.active = r_out_active;

    a_activate_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_action == ACT_ACTIVATE |-> r_out_active)
        else $error("activate result with inactive flag");

    a_deactivate_clears_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_action == ACT_DEACTIVATE |-> !r_out_active)
        else $error("deactivate result with active flag");

    a_flag_matches_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_active == r_active)
        else $error("result flag differs from state");

    a_stalled_event_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !w_out_free |=> r_s1_valid && $stable(r_s1_func))
        else $error("stalled event lost");

    a_tick_counts_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && r_s1_func == FUNC_TICK && r_idle_left != '0
        |=> r_idle_left == $past(r_idle_left) - 16'd1)
        else $error("idle countdown did not decrement");
endmodule

// ----- sv/auto_mouse_layer_control.sv -----
// Top level of the automatic mouse layer controller.
// Instantiates amlc_cfg_regs and amlc_core; depends on amlc_pkg and the channel interfaces.
//
// Events arrive on i_evt as valid/ready transactions: millisecond ticks, pointer
// motion, key position presses, keycode presses and layer-state reports. Each
// event produces exactly one result transaction on o_res with the action to take
// (none, activate or deactivate the layer), the layer it concerns and the active
// flag after the event.
// An event is captured in an input register and its result is registered in the
// result register, which drives o_res.valid; a stall on o_res can hold the event
// in the input register. One event is accepted every cycle while o_res takes each
// result; the state update between the two registers is combinational.
// When o_res stalls, the result register and the input register hold their
// transactions and i_evt.ready drops only once both are full; nothing is lost.
// The APB-style port holds five registers at byte address 8*i with always-high
// pready; write them only while no transaction is in flight.
// Synchronous reset clears the state: layer inactive, countdown stopped,
// idle_ms 1000 and all other registers zero.
module auto_mouse_layer_control (
    input  logic            i_clk,
    input  logic            i_rst_n,
    amlc_evt_if.sink        i_evt,
    amlc_res_if.source      o_res,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [5:0]      paddr,
    input  logic [63:0]     pwdata,
    output logic [63:0]     prdata,
    output logic            pready
);
    import amlc_pkg::*;

    t_cfg w_cfg;

    amlc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    amlc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_evt   (i_evt),
        .o_res   (o_res)
    );
endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// Testbench for auto_mouse_layer_control: directed, long-countdown and random event streams,
// each result transaction checked against a predictor of the layer control state.
// Depends on amlc_pkg, amlc_evt_if, amlc_res_if and the RTL.
module tb;
    import amlc_pkg::*;

    typedef struct packed {
        t_func func;
        logic  pressed;
        t_pos  position;
        logic  still_on;
    } t_event;

    typedef struct packed {
        t_action action;
        t_layer  layer;
        logic    active;
    } t_result;

    typedef enum logic [1:0] {RX_STREAM, RX_COIN, RX_MOSTLY, RX_THIRD} t_rx_mode;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 230;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [5:0]  paddr   = '0;
    logic [63:0] pwdata  = '0;
    logic [63:0] prdata;
    logic        pready;

    amlc_evt_if evt_ch();
    amlc_res_if res_ch();

    auto_mouse_layer_control DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_event   pending_events[$];
    t_result  expected_results[$];
    t_cfg     cfg;
    logic     layer_on;
    t_ms      ms_since_key;
    t_ms      idle_countdown;
    int       mismatches = 0;

    logic     evt_taken  = 1'b0;
    int       burst_left = 0;
    int       gap_left   = 0;
    int       rx_cycles  = 0;
    int       hold_left  = 0;
    int       mode_left  = 0;
    t_rx_mode rx_mode    = RX_STREAM;

    function automatic t_result next_layer_result(t_event ev);
        t_result      res;
        logic [127:0] excluded;
        res.action = ACT_NONE;
        excluded   = {cfg.excluded_high, cfg.excluded_low} & POS_MASK;
        case (ev.func)
            FUNC_TICK: begin
                if (ms_since_key != 16'hFFFF) begin
                    ms_since_key++;
                end
                if (idle_countdown != 0) begin
                    idle_countdown--;
                    if (idle_countdown == 0 && layer_on) begin
                        layer_on   = 1'b0;
                        res.action = ACT_DEACTIVATE;
                    end
                end
            end
            FUNC_MOTION: begin
                if (int'(cfg.ctrl_layer) < LAYER_COUNT) begin
                    if (!layer_on && ms_since_key >= cfg.prior_idle_ms) begin
                        layer_on   = 1'b1;
                        res.action = ACT_ACTIVATE;
                    end
                    if (cfg.idle_ms != 0) begin
                        idle_countdown = cfg.idle_ms;
                    end
                end
            end
            FUNC_POSITION: begin
                if (ev.pressed && layer_on && excluded != 0 &&
                    !(int'(ev.position) < POSITION_COUNT && excluded[ev.position])) begin
                    layer_on   = 1'b0;
                    res.action = ACT_DEACTIVATE;
                end
            end
            FUNC_KEYCODE: begin
                if (ev.pressed) begin
                    ms_since_key = '0;
                end
            end
            FUNC_REPORT: begin
                if (!ev.still_on) begin
                    layer_on       = 1'b0;
                    idle_countdown = '0;
                end
            end
            default: ;
        endcase
        res.layer  = (res.action != ACT_NONE) ? cfg.ctrl_layer : '0;
        res.active = layer_on;
        return res;
    endfunction

    function automatic void queue_event(t_func f, logic p, t_pos pos, logic on);
        t_event ev;
        ev.func     = f;
        ev.pressed  = p;
        ev.position = pos;
        ev.still_on = on;
        pending_events.push_back(ev);
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_IDLE_MS:       cfg.idle_ms       = value[15:0];
            REG_PRIOR_IDLE_MS: cfg.prior_idle_ms = value[14:0];
            REG_CTRL_LAYER:    cfg.ctrl_layer    = value[4:0];
            REG_EXCLUDED_LOW:  cfg.excluded_low  = value;
            REG_EXCLUDED_HIGH: cfg.excluded_high = value;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (pending_events.size() != 0 || expected_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        forever begin
            #10 i_clk = ~i_clk;
        end
    end

    initial begin
        #40_000_000;
        $display("FAILURE");
        $finish;
    end

    always @(posedge i_clk) begin
        t_result want;
        evt_taken <= i_rst_n && evt_ch.valid && evt_ch.ready;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: expected no transaction, got action %0d layer %0d active %0d",
                         $time, res_ch.action, res_ch.layer, res_ch.active);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (res_ch.action !== want.action) begin
                    $display("%0t: action expected %0d, got %0d",
                             $time, want.action, res_ch.action);
                    mismatches++;
                end
                if (res_ch.layer !== want.layer) begin
                    $display("%0t: layer expected %0d, got %0d",
                             $time, want.layer, res_ch.layer);
                    mismatches++;
                end
                if (res_ch.active !== want.active) begin
                    $display("%0t: active expected %0d, got %0d",
                             $time, want.active, res_ch.active);
                    mismatches++;
                end
            end
        end
        if (i_rst_n && evt_ch.valid && evt_ch.ready) begin
            expected_results.push_back(next_layer_result(pending_events.pop_front()));
        end
    end

    always @(negedge i_clk) begin
        logic offer;
        offer = 1'b0;
        if (evt_taken && burst_left != 0) begin
            burst_left--;
        end
        if (!i_rst_n) begin
            offer = 1'b0;
        end else if (evt_ch.valid && !evt_taken) begin
            offer = 1'b1;
        end else begin
            if (burst_left == 0 && gap_left == 0) begin
                burst_left = $urandom_range(1, 40);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: gap_left = 0;
                    9: gap_left = $urandom_range(5, 20);
                    default: gap_left = $urandom_range(1, 4);
                endcase
            end
            if (gap_left != 0) begin
                gap_left--;
            end else begin
                offer = pending_events.size() != 0;
            end
        end
        evt_ch.valid <= offer;
        if (offer) begin
            evt_ch.func           <= pending_events[0].func;
            evt_ch.pressed        <= pending_events[0].pressed;
            evt_ch.position       <= pending_events[0].position;
            evt_ch.layer_still_on <= pending_events[0].still_on;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            rx_cycles++;
            if (rx_cycles % 1000 == 0) begin
                hold_left = $urandom_range(40, 80);
            end
            if (mode_left == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            if (hold_left != 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_STREAM: res_ch.ready <= 1'b1;
                    RX_COIN:   res_ch.ready <= 1'($urandom_range(0, 1));
                    RX_MOSTLY: res_ch.ready <= $urandom_range(0, 3) != 0;
                    default:   res_ch.ready <= rx_cycles % 3 == 0;
                endcase
            end
        end
    end

    initial begin
        t_ms         new_idle;
        t_prior_ms   new_prior;
        t_layer      new_layer;
        logic [63:0] excl_lo;
        logic [63:0] excl_hi;
        int          roll;
        t_func       rnd_func;

        evt_ch.valid          = 1'b0;
        evt_ch.func           = FUNC_TICK;
        evt_ch.pressed        = 1'b0;
        evt_ch.position       = '0;
        evt_ch.layer_still_on = 1'b1;
        res_ch.ready          = 1'b0;
        cfg                   = '0;
        cfg.idle_ms           = t_ms'(IDLE_MS_RESET);
        layer_on              = 1'b0;
        ms_since_key          = '0;
        idle_countdown        = '0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Registers at their reset values.
        queue_event(FUNC_MOTION, 1'b0, '0, 1'b0);
        queue_event(FUNC_REPORT, 1'b0, '0, 1'b0);
        wait_idle();

        write_reg(REG_IDLE_MS, 64'd2);
        write_reg(REG_PRIOR_IDLE_MS, 64'd3);
        write_reg(REG_CTRL_LAYER, 64'd31);
        write_reg(REG_EXCLUDED_LOW, 64'd1);
        write_reg(REG_EXCLUDED_HIGH, 64'h8000_0000_0000_0000);
        queue_event(FUNC_MOTION, 1'b0, '0, 1'b1);
        queue_event(FUNC_TICK, 1'b0, '0, 1'b1);
        queue_event(FUNC_TICK, 1'b0, '0, 1'b1);
        queue_event(FUNC_TICK, 1'b0, '0, 1'b1);
        queue_event(FUNC_MOTION, 1'b0, '0, 1'b1);
        queue_event(FUNC_MOTION, 1'b0, '0, 1'b1);
        queue_event(FUNC_POSITION, 1'b1, 7'd0, 1'b1);
        queue_event(FUNC_POSITION, 1'b1, 7'd127, 1'b1);
        queue_event(FUNC_POSITION, 1'b0, 7'd5, 1'b1);
        queue_event(FUNC_POSITION, 1'b1, 7'd64, 1'b1);
        queue_event(FUNC_TICK, 1'b0, '0, 1'b1);
        queue_event(FUNC_TICK, 1'b0, '0, 1'b1);
        queue_event(FUNC_KEYCODE, 1'b0, '0, 1'b1);
        queue_event(FUNC_MOTION, 1'b0, '0, 1'b1);
        queue_event(FUNC_KEYCODE, 1'b1, '0, 1'b1);
        queue_event(FUNC_REPORT, 1'b0, '0, 1'b1);
        queue_event(FUNC_TICK, 1'b0, '0, 1'b1);
        queue_event(FUNC_TICK, 1'b0, '0, 1'b1);
        queue_event(FUNC_MOTION, 1'b0, '0, 1'b1);
        queue_event(FUNC_REPORT, 1'b1, 7'd127, 1'b0);
        for (int f = int'(FUNC_REPORT) + 1; f < 8; f++) begin
            queue_event(t_func'(f), 1'b1, 7'd127, 1'b0);
        end
        queue_event(FUNC_TICK, 1'b1, 7'd127, 1'b0);
        wait_idle();

        // Largest countdown value; a motion one tick short of the quiet time must not
        // activate the layer, and the next one must.
        write_reg(REG_IDLE_MS, 64'hFFFF);
        write_reg(REG_PRIOR_IDLE_MS, 64'd20);
        write_reg(REG_CTRL_LAYER, 64'd17);
        write_reg(REG_EXCLUDED_LOW, 64'd0);
        write_reg(REG_EXCLUDED_HIGH, 64'd0);
        queue_event(FUNC_KEYCODE, 1'b1, '0, 1'b1);
        repeat (19) queue_event(FUNC_TICK, 1'b0, '0, 1'b1);
        queue_event(FUNC_MOTION, 1'b0, '0, 1'b1);
        queue_event(FUNC_TICK, 1'b0, '0, 1'b1);
        queue_event(FUNC_MOTION, 1'b0, '0, 1'b1);
        repeat (10) queue_event(FUNC_TICK, 1'b0, '0, 1'b1);
        queue_event(FUNC_MOTION, 1'b0, '0, 1'b1);
        queue_event(FUNC_REPORT, 1'b0, '0, 1'b0);
        wait_idle();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    new_idle  = 16'd1;
                    new_prior = '0;
                    new_layer = 5'd0;
                    excl_lo   = '1;
                    excl_hi   = '1;
                end
                1: begin
                    new_idle  = '0;
                    new_prior = 15'($urandom_range(1, 20));
                    new_layer = 5'd31;
                    excl_lo   = '0;
                    excl_hi   = '0;
                end
                2: begin
                    new_idle  = 16'($urandom_range(2, 30));
                    new_prior = '0;
                    new_layer = 5'($urandom);
                    excl_lo   = 64'd1;
                    excl_hi   = '0;
                end
                3: begin
                    new_idle  = 16'($urandom_range(2, 30));
                    new_prior = 15'($urandom_range(0, 10));
                    new_layer = 5'($urandom);
                    excl_lo   = '0;
                    excl_hi   = 64'h8000_0000_0000_0000;
                end
                default: begin
                    new_idle  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 4))
                                                            : 16'($urandom_range(5, 60));
                    new_prior = 15'($urandom_range(0, 25));
                    new_layer = 5'($urandom);
                    excl_lo   = {$urandom, $urandom};
                    excl_hi   = {$urandom, $urandom};
                    if ($urandom_range(0, 2) == 0) begin
                        excl_lo = '0;
                    end
                    if ($urandom_range(0, 2) == 0) begin
                        excl_hi = excl_hi & {$urandom, $urandom};
                    end
                end
            endcase
            write_reg(REG_IDLE_MS, {$urandom, 16'($urandom), new_idle});
            write_reg(REG_PRIOR_IDLE_MS, {$urandom, 17'($urandom), new_prior});
            write_reg(REG_CTRL_LAYER, {$urandom, 27'($urandom), new_layer});
            write_reg(REG_EXCLUDED_LOW, excl_lo);
            write_reg(REG_EXCLUDED_HIGH, excl_hi);
            repeat (ITEMS_PER_PHASE) begin
                roll = $urandom_range(0, 99);
                if (roll < 40) begin
                    rnd_func = FUNC_TICK;
                end else if (roll < 58) begin
                    rnd_func = FUNC_MOTION;
                end else if (roll < 73) begin
                    rnd_func = FUNC_POSITION;
                end else if (roll < 83) begin
                    rnd_func = FUNC_KEYCODE;
                end else if (roll < 94) begin
                    rnd_func = FUNC_REPORT;
                end else begin
                    rnd_func = t_func'($urandom_range(int'(FUNC_REPORT) + 1, 7));
                end
                queue_event(rnd_func, 1'($urandom_range(0, 1)), t_pos'($urandom),
                            $urandom_range(0, 3) != 0);
            end
            wait_idle();
        end

        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/amlc_pkg.sv
sv/amlc_evt_if.sv
sv/amlc_res_if.sv
sv/amlc_cfg_regs.sv
sv/amlc_core.sv
sv/auto_mouse_layer_control.sv
bench/tb.sv
